// ===== rtl/fcce_pkg.sv =====
package fcce_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned CountW = 13;
  localparam int unsigned StatW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_LENGTH = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_FREE   = 3'd4,
    CMD_RESIZE = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_NOFREE = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  localparam logic [27:0] EntryEndMin = 28'hFFFFFF8;
  localparam logic [31:0] EndMark     = 32'hFFFFFFFF;
  localparam int unsigned SearchFloor = 3;

endpackage

// ===== rtl/fat_cluster_chain_engine.sv =====
// Flow per command: write and unknown commands go straight to the result; read waits
// for the table read; chain length walks the chain; free chain walks it, then frees
// each member; find free scans the entries; resize walks the chain, then frees the
// tail, or counts free entries over the volume and appends clusters.
// Throughput: one command at a time; a held result does not block the next transfer.
// Reset: control clears, limit 4096; the table holds undefined data until written.
module fat_cluster_chain_engine #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command_i,
  input  logic [11:0] cluster_i,
  input  logic [31:0] entry_value_i,
  input  logic [12:0] target_clusters_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value_o,
  output logic [12:0] result_count_o,
  output logic [1:0]  status_o
);
  import fcce_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned LW = (AW + 1 > CountW) ? AW + 1 : CountW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WALK   = 4'd1;
  localparam logic [3:0] S_WALKR  = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_SCANR  = 4'd4;
  localparam logic [3:0] S_FREE   = 4'd5;
  localparam logic [3:0] S_FREER  = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;
  localparam logic [3:0] S_RDWAIT = 4'd8;
  localparam logic [3:0] S_CNT    = 4'd9;
  localparam logic [3:0] S_CNTR   = 4'd10;
  localparam logic [3:0] S_APP    = 4'd11;
  localparam logic [3:0] S_APPR   = 4'd12;

  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rdata_q;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;
  logic        re;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  logic [3:0]  state_q, state_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [12:0] tgt_q, tgt_d;
  logic [LW-1:0] cur_q, cur_d;      // current cluster
  logic [LW-1:0] start_q, start_d;
  logic [LW-1:0] prev_q, prev_d;
  logic [LW-1:0] n_q, n_d;          // counter
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] need_q, need_d;
  logic [31:0] rval_q, rval_d;
  logic [12:0] rcnt_q, rcnt_d;
  logic [1:0]  rst_q, rst_d;
  logic [31:0] res_val_q, res_val_d;
  logic [12:0] res_cnt_q, res_cnt_d;
  logic [1:0]  res_st_q, res_st_d;
  logic        ov_q, ov_d;
  logic [12:0] lim_cfg_q;
  logic [LW-1:0] lim;
  logic [LW-1:0] nxt;
  logic [27:0] rd28;
  logic        rd_end;

  assign cfg_ready = (state_q == S_IDLE) && !ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lim_cfg_q <= 13'd4096;
    else if (cfg_valid && cfg_ready) lim_cfg_q <= cfg_data;
  end
  always_comb begin
    if (32'(lim_cfg_q) < TABLE_DEPTH) lim = LW'(lim_cfg_q);
    else lim = LW'(TABLE_DEPTH);
  end

  assign rd28   = rdata_q[27:0];
  assign rd_end = rd28 >= EntryEndMin;
  assign nxt    = (rd28 >= 28'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(rd28);

  assign in_stall = (state_q != S_IDLE);
  assign out_valid = ov_q;
  assign result_value_o = res_val_q;
  assign result_count_o = res_cnt_q;
  assign status_o = res_st_q;

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; tgt_d = tgt_q;
    cur_d = cur_q; start_d = start_q; prev_d = prev_q; n_d = n_q;
    len_d = len_q; need_d = need_q;
    rval_d = rval_q; rcnt_d = rcnt_q; rst_d = rst_q; ov_d = ov_q;
    res_val_d = res_val_q; res_cnt_d = res_cnt_q; res_st_d = res_st_q;
    we = 1'b0; waddr = cur_q[AW-1:0]; wdata = 32'd0;
    re = 1'b0; raddr = cur_q[AW-1:0];
    if (ov_q && !out_stall) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd_d = command_i; tgt_d = target_clusters_i;
          cur_d = LW'(cluster_i); start_d = LW'(cluster_i);
          rval_d = '0; rcnt_d = '0; rst_d = ST_OK; n_d = '0; len_d = '0;
          case (command_i)
            CMD_WRITE, CMD_READ: begin
              if (32'(cluster_i) >= TABLE_DEPTH) begin
                rst_d = ST_RANGE; state_d = S_OUT;
              end else if (command_i == CMD_WRITE) begin
                we = 1'b1; waddr = AW'(cluster_i); wdata = entry_value_i;
                state_d = S_OUT;
              end else begin
                re = 1'b1; raddr = AW'(cluster_i); state_d = S_RDWAIT;
              end
            end
            CMD_LENGTH, CMD_FREE, CMD_RESIZE: state_d = S_WALK;
            CMD_FIND: begin
              if (cluster_i < 12'(SearchFloor)) cur_d = LW'(SearchFloor);
              state_d = S_SCAN;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_RDWAIT: begin
        rval_d = rdata_q; state_d = S_OUT;
      end
      S_WALK: begin
        if (start_q == '0) begin
          len_d = '0; state_d = S_WALKR; n_d = '0;
        end else if (cur_q < LW'(2) || cur_q >= lim || n_q >= lim) begin
          rst_d = ST_RANGE; state_d = S_OUT;
        end else begin
          re = 1'b1; n_d = n_q + 1'b1; prev_d = cur_q; state_d = S_WALKR;
        end
      end
      S_WALKR: begin
        if (start_q == '0 || rd_end) begin
          len_d = n_q;
          case (cmd_q)
            CMD_LENGTH: begin rcnt_d = 13'(n_q); state_d = S_OUT; end
            CMD_FREE: begin
              rcnt_d = 13'(n_q); cur_d = start_q; n_d = '0; need_d = n_q;
              state_d = S_FREE;
            end
            default: begin
              if (LW'(tgt_q) == n_q) begin
                rval_d = 32'(start_q); rcnt_d = 13'(n_q); state_d = S_OUT;
              end else if (LW'(tgt_q) < n_q) begin
                // free members from index tgt (0-based), end-mark member tgt-1
                cur_d = start_q; n_d = '0; need_d = n_q;
                if (tgt_q != '0) begin rval_d = 32'(start_q); rcnt_d = tgt_q; end
                state_d = S_FREE;
              end else begin
                // prev_q holds the tail; count free entries
                cur_d = LW'(SearchFloor); n_d = '0; state_d = S_CNT;
              end
            end
          endcase
        end else begin
          cur_d = nxt; state_d = S_WALK;
        end
      end
      S_FREE: begin
        if (n_q >= need_q) state_d = S_OUT;
        else begin re = 1'b1; state_d = S_FREER; end
      end
      S_FREER: begin
        if (cmd_q == CMD_RESIZE && n_q + 1'b1 == LW'(tgt_q)) begin
          we = 1'b1; wdata = EndMark;
        end else if (cmd_q == CMD_FREE || n_q >= LW'(tgt_q)) begin
          we = 1'b1; wdata = 32'd0;
        end
        n_d = n_q + 1'b1; cur_d = nxt; state_d = S_FREE;
      end
      S_SCAN: begin
        if (cur_q >= lim) begin
          if (cmd_q == CMD_FIND) rst_d = ST_NOFREE;
          state_d = S_OUT;
        end else begin re = 1'b1; state_d = S_SCANR; end
      end
      S_SCANR: begin
        if (rd28 == '0) begin
          if (cmd_q == CMD_FIND) begin
            rval_d = 32'(cur_q); state_d = S_OUT;
          end else begin
            state_d = S_APP;
          end
        end else begin
          cur_d = cur_q + 1'b1; state_d = S_SCAN;
        end
      end
      S_CNT: begin
        if (cur_q >= lim) begin
          if (n_q < LW'(tgt_q) - len_q) begin
            rst_d = ST_NOFREE; state_d = S_OUT;
          end else begin
            rval_d = (len_q == '0) ? 32'd0 : 32'(start_q);
            rcnt_d = tgt_q; need_d = LW'(tgt_q) - len_q; n_d = '0;
            cur_d = LW'(SearchFloor); state_d = S_SCAN;
          end
        end else begin re = 1'b1; state_d = S_CNTR; end
      end
      S_CNTR: begin
        if (rd28 == '0) n_d = n_q + 1'b1;
        cur_d = cur_q + 1'b1; state_d = S_CNT;
      end
      S_APP: begin
        // cur_q is free: mark end, link prev
        we = 1'b1; wdata = EndMark; state_d = S_APPR;
      end
      S_APPR: begin
        if (n_q == '0 && len_q == '0) rval_d = 32'(cur_q);
        else begin we = 1'b1; waddr = prev_q[AW-1:0]; wdata = 32'(cur_q); end
        prev_d = cur_q; n_d = n_q + 1'b1;
        if (n_q + 1'b1 >= need_q) state_d = S_OUT;
        else begin cur_d = cur_q + 1'b1; state_d = S_SCAN; end
      end
      S_OUT: begin
        if (!ov_q || !out_stall) begin
          ov_d = 1'b1; state_d = S_IDLE;
          res_val_d = rval_q; res_cnt_d = rcnt_q; res_st_d = rst_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; tgt_q <= tgt_d; cur_q <= cur_d;
    start_q <= start_d; prev_q <= prev_d; n_q <= n_d; len_q <= len_d;
    need_q <= need_d; rval_q <= rval_d; rcnt_q <= rcnt_d; rst_q <= rst_d;
    res_val_q <= res_val_d; res_cnt_q <= res_cnt_d; res_st_q <= res_st_d;
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready |-> (state_q == S_IDLE)) else $error("cfg while busy");
`endif

endmodule
